### hw/rtl/dfc_pkg.sv
package dfc_pkg;

   // Set size and field widths
   localparam int MAX_JOBS = 1024;
   localparam int DUR_W    = 32;
   localparam int DL_W     = 32;
   localparam int IDX_W    = $clog2(MAX_JOBS);
   localparam int CNT_W    = $clog2(MAX_JOBS + 1);
   // Running total never exceeds MAX_JOBS * (2^DUR_W - 1)
   localparam int TOTAL_W  = DUR_W + CNT_W;
   localparam int JOB_W    = DUR_W + DL_W;

   typedef struct packed {
      logic [DUR_W-1:0] duration;
      logic [DL_W-1:0]  deadline;
   } job_type;

   // Operands of the shared add / compare unit
   typedef struct packed {
      logic [TOTAL_W-1:0] op_a;
      logic [TOTAL_W-1:0] op_b;
   } alu_in_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] sum;
      logic               gt;
   } alu_out_type;

endpackage

### hw/rtl/dfc_req_if.sv
interface dfc_req_if;
   logic                       valid;
   logic                       ready;
   logic [dfc_pkg::DUR_W-1:0]  duration;
   logic [dfc_pkg::DL_W-1:0]   deadline;
   logic                       is_last;

   modport source (output valid, output duration, output deadline, output is_last,
                   input ready);
   modport sink   (input valid, input duration, input deadline, input is_last,
                   output ready);
endinterface

### hw/rtl/dfc_rsp_if.sv
interface dfc_rsp_if;
   logic valid;
   logic ready;
   logic feasible;
   logic overflow;

   modport source (output valid, output feasible, output overflow, input ready);
   modport sink   (input valid, input feasible, input overflow, output ready);
endinterface

### hw/rtl/deadline_feasibility_check_core.sv
// Job transfer: sorted insert; each stored job with a later deadline moves up one slot
// (one RAM read and one write per shifted entry). Set-closing transfer: the insert, then a
// deadline walk over the stored jobs (read, add, compare per job), then the result load,
// held while the result slot is full; walk stops at a miss, skipped after an overflow.
// A job dropped on a full set is not stored and, if it closes the set, goes to the result load.
// One job at a time. Synchronous reset empties the set at once; the job RAM needs no clearing.
module deadline_feasibility_check_core (
   input logic            clock,
   input logic            reset,
   dfc_req_if.sink        req_bus,
   dfc_rsp_if.source      rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_WALK_RD,
      ST_WALK_ADD,
      ST_WALK_CMP,
      ST_FINISH
   } state_type;

   state_type                      state_ff, state_in;
   logic [dfc_pkg::CNT_W-1:0]      count_ff, count_in;
   logic                           ovf_ff, ovf_in;
   logic [dfc_pkg::CNT_W-1:0]      pos_ff, pos_in;
   dfc_pkg::job_type               new_job_ff, new_job_in;
   logic                           last_ff, last_in;
   logic [dfc_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic [dfc_pkg::CNT_W-1:0]      walk_idx_ff, walk_idx_in;
   logic                           fail_ff, fail_in;
   logic [dfc_pkg::DL_W-1:0]       dl_hold_ff, dl_hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_feasible_ff, rsp_feasible_in;
   logic                           rsp_overflow_ff, rsp_overflow_in;

   logic                           ram_wr_en;
   logic [dfc_pkg::IDX_W-1:0]      ram_wr_addr;
   dfc_pkg::job_type               ram_wr_job;
   logic                           ram_rd_en;
   logic [dfc_pkg::IDX_W-1:0]      ram_rd_addr;
   logic [dfc_pkg::JOB_W-1:0]      ram_rd_data;
   dfc_pkg::job_type               rd_job;
   dfc_pkg::alu_in_type            alu_in;
   dfc_pkg::alu_out_type           alu_out;
   logic                           req_xfer;
   logic                           rsp_free;
   logic [dfc_pkg::CNT_W-1:0]      pos_dec;

   dfc_job_ram #(
      .DEPTH (dfc_pkg::MAX_JOBS),
      .WIDTH (dfc_pkg::JOB_W)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_job),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dfc_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign rd_job   = dfc_pkg::job_type'(ram_rd_data);
   assign req_xfer = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign pos_dec  = pos_ff - dfc_pkg::CNT_W'(1);

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.feasible = rsp_feasible_ff;
   assign rsp_bus.overflow = rsp_overflow_ff;

   // Sequencer: sorted insert, deadline walk, result load
   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      pos_in          = pos_ff;
      new_job_in      = new_job_ff;
      last_in         = last_ff;
      total_in        = total_ff;
      walk_idx_in     = walk_idx_ff;
      fail_in         = fail_ff;
      dl_hold_in      = dl_hold_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_feasible_in = rsp_feasible_ff;
      rsp_overflow_in = rsp_overflow_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = pos_ff[dfc_pkg::IDX_W-1:0];
      ram_wr_job      = new_job_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = pos_dec[dfc_pkg::IDX_W-1:0];
      alu_in.op_a     = total_ff;
      alu_in.op_b     = dfc_pkg::TOTAL_W'(dl_hold_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               new_job_in.duration = req_bus.duration;
               new_job_in.deadline = req_bus.deadline;
               last_in             = req_bus.is_last;
               pos_in              = count_ff;
               if (count_ff == dfc_pkg::CNT_W'(dfc_pkg::MAX_JOBS)) begin
                  // Drop the job when the set is full
                  ovf_in = 1'b1;
                  if (req_bus.is_last) begin
                     fail_in  = 1'b1;
                     state_in = ST_FINISH;
                  end
               end else begin
                  state_in = ST_INS_RD;
               end
            end
         end

         ST_INS_RD: begin
            if (pos_ff == '0) begin
               // Place the new job at the bottom of the store
               ram_wr_en = 1'b1;
               count_in  = count_ff + dfc_pkg::CNT_W'(1);
               if (last_ff) begin
                  total_in    = '0;
                  walk_idx_in = '0;
                  fail_in     = ovf_ff;
                  state_in    = ovf_ff ? ST_FINISH : ST_WALK_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_INS_CMP;
            end
         end

         ST_INS_CMP: begin
            alu_in.op_a = dfc_pkg::TOTAL_W'(rd_job.deadline);
            alu_in.op_b = dfc_pkg::TOTAL_W'(new_job_ff.deadline);
            ram_wr_en   = 1'b1;
            if (alu_out.gt) begin
               // Shift the later-deadline job up one slot
               ram_wr_job = rd_job;
               pos_in     = pos_dec;
               state_in   = ST_INS_RD;
            end else begin
               count_in = count_ff + dfc_pkg::CNT_W'(1);
               if (last_ff) begin
                  total_in    = '0;
                  walk_idx_in = '0;
                  fail_in     = ovf_ff;
                  state_in    = ovf_ff ? ST_FINISH : ST_WALK_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_WALK_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = walk_idx_ff[dfc_pkg::IDX_W-1:0];
            state_in    = ST_WALK_ADD;
         end

         ST_WALK_ADD: begin
            // Accumulate the duration, hold the deadline for the compare
            alu_in.op_a = total_ff;
            alu_in.op_b = dfc_pkg::TOTAL_W'(rd_job.duration);
            total_in    = alu_out.sum;
            dl_hold_in  = rd_job.deadline;
            walk_idx_in = walk_idx_ff + dfc_pkg::CNT_W'(1);
            state_in    = ST_WALK_CMP;
         end

         ST_WALK_CMP: begin
            alu_in.op_a = total_ff;
            alu_in.op_b = dfc_pkg::TOTAL_W'(dl_hold_ff);
            if (alu_out.gt) begin
               fail_in  = 1'b1;
               state_in = ST_FINISH;
            end else if (walk_idx_ff == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_WALK_RD;
            end
         end

         ST_FINISH: begin
            // Load the result once the output slot is free, then empty the set
            if (rsp_free) begin
               rsp_valid_in    = 1'b1;
               rsp_feasible_in = !fail_ff;
               rsp_overflow_in = ovf_ff;
               count_in        = '0;
               ovf_in          = 1'b0;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff          <= pos_in;
      new_job_ff      <= new_job_in;
      last_ff         <= last_in;
      total_ff        <= total_in;
      walk_idx_ff     <= walk_idx_in;
      fail_ff         <= fail_in;
      dl_hold_ff      <= dl_hold_in;
      rsp_feasible_ff <= rsp_feasible_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

endmodule

### hw/rtl/dfc_job_ram.sv
module dfc_job_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/dfc_alu.sv
module dfc_alu (
   input  dfc_pkg::alu_in_type  alu_in,
   output dfc_pkg::alu_out_type alu_out
);

   // Shared adder and magnitude compare
   always_comb begin
      alu_out.sum = alu_in.op_a + alu_in.op_b;
      alu_out.gt  = alu_in.op_a > alu_in.op_b;
   end

endmodule
